>>> rtl/cpba_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helper functions for the page bitmap allocator.
// No dependencies; every other file imports this package.
package cpba_pkg;

    // default geometry of the managed segment
    localparam int PAGES_PER_SEGMENT_DEF = 512;
    localparam int PAGE_SHIFT_DEF        = 12;

    // fixed field widths
    localparam int ADDR_W   = 48;
    localparam int COUNT_W  = 10;
    localparam int INDEX_W  = 9;
    localparam int AVAIL_W  = 10;
    localparam int STATUS_W = 2;

    // bitmap storage: 32-page rows, scanned 8 pages per cycle
    localparam int ROW_BITS      = 32;
    localparam int ROW_SHIFT     = 5;
    localparam int STEP_BITS     = 8;
    localparam int STEPS_PER_ROW = ROW_BITS / STEP_BITS;
    localparam int SUB_W         = 2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NO_RUN    = 2'd1,
        ST_BAD_ADDR  = 2'd2,
        ST_OVER_FREE = 2'd3
    } status_t;

    // bitmap control from the sequencer
    typedef struct packed {
        logic we;
        logic clear_all;
    } map_ctl_t;

    function automatic int rows_of(input int pages);
        return (pages + ROW_BITS - 1) / ROW_BITS;
    endfunction

    function automatic int row_aw_of(input int pages);
        int rows;
        rows = (pages + ROW_BITS - 1) / ROW_BITS;
        return (rows > 1) ? $clog2(rows) : 1;
    endfunction

endpackage

>>> rtl/cpba_req_if.sv
`timescale 1ns / 1ps
// Request channel: opcode, page count and page address with valid/ready.
// Depends on cpba_pkg.
interface cpba_req_if
    import cpba_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              opcode;
    logic [COUNT_W-1:0] num_pages;
    logic [ADDR_W-1:0]  page_address;

    modport source (output valid, output opcode, output num_pages,
                    output page_address, input ready);
    modport sink   (input valid, input opcode, input num_pages,
                    input page_address, output ready);
endinterface

>>> rtl/cpba_rsp_if.sv
`timescale 1ns / 1ps
// Response channel: status, run address/index, free count, empty flag.
// Depends on cpba_pkg.
interface cpba_rsp_if
    import cpba_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   run_address;
    logic [INDEX_W-1:0]  run_index;
    logic [AVAIL_W-1:0]  pages_available;
    logic                segment_empty;

    modport source (output valid, output status, output run_address,
                    output run_index, output pages_available,
                    output segment_empty, input ready);
    modport sink   (input valid, input status, input run_address,
                    input run_index, input pages_available,
                    input segment_empty, output ready);
endinterface

>>> rtl/cpba_map.sv
`timescale 1ns / 1ps
// Used-page bitmap: row memory with registered read and per-row valid bits.
// Depends on cpba_pkg.
module cpba_map
    import cpba_pkg::*;
#(
    parameter int PAGES_PER_SEGMENT = PAGES_PER_SEGMENT_DEF
)(
    input  logic                              clk,
    input  logic                              rst_n,
    input  map_ctl_t                          ctl,
    input  logic [row_aw_of(PAGES_PER_SEGMENT)-1:0] addr,
    input  logic [ROW_BITS-1:0]               wdata,
    output logic [ROW_BITS-1:0]               rdata
);

    localparam int ROWS   = rows_of(PAGES_PER_SEGMENT);

    logic [ROW_BITS-1:0] mem [ROWS];
    logic [ROWS-1:0]     valid_reg;
    logic [ROW_BITS-1:0] rd_reg;
    logic                rdv_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[addr] <= wdata;
        end
        rd_reg <= mem[addr];
    end

    // a row never written since reset or the last full clear reads as free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rdv_reg   <= 1'b0;
        end
        else
        begin
            if (ctl.clear_all)
            begin
                valid_reg <= '0;
            end
            else if (ctl.we)
            begin
                valid_reg[addr] <= 1'b1;
            end
            rdv_reg <= valid_reg[addr];
        end
    end

    assign rdata = rdv_reg ? rd_reg : '0;

endmodule

>>> rtl/contiguous_page_bitmap_allocator.sv
`timescale 1ns / 1ps
// Contiguous page bitmap allocator, top level: sequencer, scan unit, result register.
// Depends on cpba_pkg, cpba_req_if, cpba_rsp_if and cpba_map.
//
// Usage:
//   req carries one request: opcode 0 allocates num_pages contiguous pages
//   (first fit, lowest index), opcode 1 frees num_pages pages at
//   page_address. rsp returns exactly one response per request. cfg_we writes
//   segment_base from cfg_wdata; write it only while no request is in flight.
//   One request at a time. A free checks the address, plans the run, then reads
//   and writes back each bitmap row touched. An allocate scans 8 pages per cycle
//   through one step unit, a 32-page row at a time, then reads and writes back
//   each row marked before it posts the response. The 8-page step unit sets the
//   scan pace.
//   Reset: all pages free, free count = PAGES_PER_SEGMENT, base = 0; the map
//   rows are marked invalid at once, so no clearing pass is needed.
//   Stall: the response sits in an output register; req.ready rises again
//   as soon as the sequencer is idle, and a finished request waits for the
//   output register to drain before it posts.
module contiguous_page_bitmap_allocator
    import cpba_pkg::*;
#(
    parameter int PAGES_PER_SEGMENT = PAGES_PER_SEGMENT_DEF,
    parameter int PAGE_SHIFT        = PAGE_SHIFT_DEF
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [ADDR_W-1:0] cfg_wdata,
    cpba_req_if.sink          req,
    cpba_rsp_if.source        rsp
);

    localparam int IDX_W  = $clog2(PAGES_PER_SEGMENT);
    localparam int CNT_W  = $clog2(PAGES_PER_SEGMENT + 1);
    localparam int CMP_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int POS_W  = $clog2(PAGES_PER_SEGMENT + STEP_BITS + 1);
    localparam int ROW_AW = row_aw_of(PAGES_PER_SEGMENT);
    localparam int MW     = ROW_AW + ROW_SHIFT + 1;
    localparam int OFF_W  = ADDR_W + 1;
    localparam logic [OFF_W-1:0] SPAN    = OFF_W'(PAGES_PER_SEGMENT) << PAGE_SHIFT;
    localparam logic [CNT_W-1:0] PAGES_C = CNT_W'(PAGES_PER_SEGMENT);
    localparam logic [POS_W-1:0] PAGES_P = POS_W'(PAGES_PER_SEGMENT);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_FETCH  = 9'b000000010,
        S_LOAD   = 9'b000000100,
        S_SCAN   = 9'b000001000,
        S_CHECK  = 9'b000010000,
        S_PLAN   = 9'b000100000,
        S_MREAD  = 9'b001000000,
        S_MWRITE = 9'b010000000,
        S_DONE   = 9'b100000000
    } state_t;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   base_reg, base_next;
    logic [CNT_W-1:0]    free_reg, free_next;
    logic                op_reg, op_next;
    logic [COUNT_W-1:0]  cnt_reg, cnt_next;
    logic [ADDR_W-1:0]   va_reg, va_next;
    logic [IDX_W-1:0]    lo_reg, lo_next;
    logic [CNT_W-1:0]    hi_reg, hi_next;
    logic [ROW_AW-1:0]   row_reg, row_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [CNT_W-1:0]    run_reg, run_next;
    logic [IDX_W-1:0]    start_reg, start_next;
    logic [SUB_W-1:0]    sub_reg, sub_next;
    logic [ROW_BITS-1:0] word_reg, word_next;
    status_t             status_reg, status_next;

    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg, out_status_next;
    logic [ADDR_W-1:0]   out_addr_reg, out_addr_next;
    logic [INDEX_W-1:0]  out_index_reg, out_index_next;
    logic [AVAIL_W-1:0]  out_avail_reg, out_avail_next;
    logic                out_empty_reg, out_empty_next;

    map_ctl_t            map_ctl;
    logic [ROW_BITS-1:0] map_rdata;
    logic [ROW_BITS-1:0] map_wdata;
    logic [ROW_BITS-1:0] row_mask;

    logic                scan_hit;
    logic [CNT_W-1:0]    scan_run;
    logic [IDX_W-1:0]    scan_start;
    logic [POS_W-1:0]    pos_inc;

    logic [OFF_W-1:0]    off;
    logic [CNT_W-1:0]    used;
    logic [CMP_W:0]      hi_sum;
    logic [CNT_W-1:0]    free_plus;
    logic [CNT_W-1:0]    hi_m1;
    logic [ROW_AW-1:0]   last_row;
    logic                res_ok;

    cpba_map #(
        .PAGES_PER_SEGMENT (PAGES_PER_SEGMENT)
    ) u_map (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (map_ctl),
        .addr  (row_reg),
        .wdata (map_wdata),
        .rdata (map_rdata)
    );

    // scan step: 8 pages of the current row, carrying run length and start
    always_comb
    begin : scan_step
        logic [CNT_W-1:0] run_v;
        logic [IDX_W-1:0] start_v;
        logic             hit_v;
        logic [POS_W-1:0] page_v;
        run_v   = run_reg;
        start_v = start_reg;
        hit_v   = 1'b0;
        for (int j = 0; j < STEP_BITS; j++)
        begin
            page_v = pos_reg + POS_W'(j);
            if (!hit_v && (page_v < PAGES_P))
            begin
                if (word_reg[j])
                begin
                    start_v = IDX_W'(page_v + POS_W'(1));
                    run_v   = '0;
                end
                else
                begin
                    run_v = run_v + CNT_W'(1);
                end
                if (CMP_W'(run_v) == CMP_W'(cnt_reg))
                begin
                    hit_v = 1'b1;
                end
            end
        end
        scan_run   = run_v;
        scan_start = start_v;
        scan_hit   = hit_v;
    end

    // pages of the current row that fall in [lo, hi)
    always_comb
    begin : mask_gen
        logic [MW-1:0] page_v;
        for (int b = 0; b < ROW_BITS; b++)
        begin
            page_v      = {1'b0, row_reg, ROW_SHIFT'(b)};
            row_mask[b] = (page_v >= MW'(lo_reg)) && (page_v < MW'(hi_reg));
        end
    end

    assign map_wdata = (op_reg == OP_ALLOC) ? (map_rdata | row_mask)
                                            : (map_rdata & ~row_mask);

    assign pos_inc   = pos_reg + POS_W'(STEP_BITS);
    assign off       = {1'b0, va_reg} - {1'b0, base_reg};
    assign used      = PAGES_C - free_reg;
    assign hi_sum    = (CMP_W + 1)'(lo_reg) + (CMP_W + 1)'(cnt_reg);
    assign free_plus = free_reg + CNT_W'(cnt_reg);
    assign hi_m1     = hi_reg - CNT_W'(1);
    assign last_row  = ROW_AW'(hi_m1 >> ROW_SHIFT);
    assign res_ok    = (status_reg == ST_OK);

    always_comb
    begin
        state_next      = state_reg;
        base_next       = base_reg;
        free_next       = free_reg;
        op_next         = op_reg;
        cnt_next        = cnt_reg;
        va_next         = va_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        row_next        = row_reg;
        pos_next        = pos_reg;
        run_next        = run_reg;
        start_next      = start_reg;
        sub_next        = sub_reg;
        word_next       = word_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        out_index_next  = out_index_reg;
        out_avail_next  = out_avail_reg;
        out_empty_next  = out_empty_reg;
        map_ctl         = '0;

        if (cfg_we)
        begin
            base_next = cfg_wdata;
        end
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next     = req.opcode;
                    cnt_next    = req.num_pages;
                    va_next     = req.page_address;
                    row_next    = '0;
                    pos_next    = '0;
                    run_next    = '0;
                    start_next  = '0;
                    sub_next    = '0;
                    lo_next     = '0;
                    status_next = ST_OK;
                    if (req.opcode == OP_FREE)
                    begin
                        state_next = S_CHECK;
                    end
                    else if ((req.num_pages == '0) ||
                             (CMP_W'(req.num_pages) > CMP_W'(free_reg)))
                    begin
                        status_next = ST_NO_RUN;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_FETCH;
                    end
                end
            end
            S_FETCH:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                // next row's read overlaps the scan of this one
                word_next  = map_rdata;
                row_next   = row_reg + ROW_AW'(1);
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                run_next   = scan_run;
                start_next = scan_start;
                pos_next   = pos_inc;
                word_next  = word_reg >> STEP_BITS;
                sub_next   = sub_reg + SUB_W'(1);
                if (scan_hit)
                begin
                    lo_next    = scan_start;
                    hi_next    = CNT_W'(scan_start) + CNT_W'(cnt_reg);
                    free_next  = free_reg - CNT_W'(cnt_reg);
                    row_next   = ROW_AW'(scan_start >> ROW_SHIFT);
                    state_next = S_MREAD;
                end
                else if (pos_inc >= PAGES_P)
                begin
                    status_next = ST_NO_RUN;
                    state_next  = S_DONE;
                end
                else if (sub_reg == SUB_W'(STEPS_PER_ROW - 1))
                begin
                    word_next = map_rdata;
                    row_next  = row_reg + ROW_AW'(1);
                end
            end
            S_CHECK:
            begin
                if (off[OFF_W-1] || (off >= SPAN))
                begin
                    status_next = ST_BAD_ADDR;
                    state_next  = S_DONE;
                end
                else
                begin
                    lo_next    = off[PAGE_SHIFT +: IDX_W];
                    state_next = S_PLAN;
                end
            end
            S_PLAN:
            begin
                if (CMP_W'(cnt_reg) > CMP_W'(used))
                begin
                    status_next = ST_OVER_FREE;
                    state_next  = S_DONE;
                end
                else
                begin
                    free_next = free_plus;
                    // run is clipped at the segment end
                    hi_next   = (hi_sum > (CMP_W + 1)'(PAGES_PER_SEGMENT))
                                ? PAGES_C : CNT_W'(hi_sum);
                    row_next  = ROW_AW'(lo_reg >> ROW_SHIFT);
                    if (free_plus == PAGES_C)
                    begin
                        // whole segment free: drop every row at once
                        map_ctl.clear_all = 1'b1;
                        state_next        = S_DONE;
                    end
                    else if (cnt_reg == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_MREAD;
                    end
                end
            end
            S_MREAD:
            begin
                state_next = S_MWRITE;
            end
            S_MWRITE:
            begin
                map_ctl.we = 1'b1;
                if (row_reg == last_row)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    row_next   = row_reg + ROW_AW'(1);
                    state_next = S_MREAD;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_addr_next   = res_ok
                                      ? base_reg + (ADDR_W'(lo_reg) << PAGE_SHIFT)
                                      : '0;
                    out_index_next  = res_ok ? INDEX_W'(lo_reg) : '0;
                    out_avail_next  = AVAIL_W'(free_reg);
                    out_empty_next  = res_ok && (op_reg == OP_FREE) &&
                                      (free_reg == PAGES_C);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            base_reg      <= '0;
            free_reg      <= PAGES_C;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            free_reg      <= free_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        cnt_reg        <= cnt_next;
        va_reg         <= va_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        row_reg        <= row_next;
        pos_reg        <= pos_next;
        run_reg        <= run_next;
        start_reg      <= start_next;
        sub_reg        <= sub_next;
        word_reg       <= word_next;
        status_reg     <= status_next;
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
        out_index_reg  <= out_index_next;
        out_avail_reg  <= out_avail_next;
        out_empty_reg  <= out_empty_next;
    end

    assign req.ready           = (state_reg == S_IDLE);
    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_status_reg;
    assign rsp.run_address     = out_addr_reg;
    assign rsp.run_index       = out_index_reg;
    assign rsp.pages_available = out_avail_reg;
    assign rsp.segment_empty   = out_empty_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        free_reg <= PAGES_C)
        else $error("free page count above segment size");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MWRITE) |-> (row_reg <= last_row))
        else $error("bitmap update past last row of run");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && !rsp.ready) |=>
        (state_reg == S_DONE && out_valid_reg))
        else $error("response posted over an untaken response");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |->
        (cnt_reg != '0 && CMP_W'(cnt_reg) <= CMP_W'(free_reg)))
        else $error("scan started for an impossible count");

endmodule

>>> bench/tb_contiguous_page_bitmap_allocator.sv
`timescale 1ns / 1ps
// Self-checking bench for the page bitmap allocator: a scoreboard class keeps its own
// page map, free count and segment base, and checks every response in order.
// Depends on cpba_pkg, cpba_req_if, cpba_rsp_if and the allocator RTL.

typedef struct packed {
    cpba_pkg::status_t                 status;
    logic [cpba_pkg::ADDR_W-1:0]       run_address;
    logic [cpba_pkg::INDEX_W-1:0]      run_index;
    logic [cpba_pkg::AVAIL_W-1:0]      pages_available;
    logic                              segment_empty;
} alloc_result_t;

class page_alloc_scoreboard;
    localparam int PAGES = cpba_pkg::PAGES_PER_SEGMENT_DEF;
    localparam int SHIFT = cpba_pkg::PAGE_SHIFT_DEF;

    bit                          page_used[PAGES];
    // free page count, capped at the segment size on a free
    int unsigned                 free_pages = PAGES;
    logic [cpba_pkg::ADDR_W-1:0] base = '0;
    alloc_result_t               awaited[$];
    int unsigned                 mismatches = 0;
    int unsigned                 n_alloc_ok = 0;
    int unsigned                 n_free_ok  = 0;
    int unsigned                 n_reject   = 0;
    int unsigned                 n_empty    = 0;

    function void set_base(input logic [cpba_pkg::ADDR_W-1:0] value);
        base = value;
    endfunction

    // Called when a request is accepted; works out the response it must produce.
    function void note_request(input logic op, input logic [cpba_pkg::COUNT_W-1:0] cnt,
                               input logic [cpba_pkg::ADDR_W-1:0] addr);
        alloc_result_t exp_rsp;
        int unsigned   run;
        int unsigned   start;
        int unsigned   idx;
        int unsigned   used;
        bit            found;
        logic [63:0]   va;
        logic [63:0]   lo;
        logic [63:0]   hi;
        logic [63:0]   run_addr;

        exp_rsp.status          = cpba_pkg::ST_NO_RUN;
        exp_rsp.run_address     = '0;
        exp_rsp.run_index       = '0;
        exp_rsp.segment_empty   = 1'b0;
        lo = {16'b0, base};
        if (op == cpba_pkg::OP_ALLOC)
        begin
            found = 0;
            start = 0;
            run   = 0;
            if (cnt != 0)
            begin
                for (int i = 0; i < PAGES && !found; i++)
                begin
                    if (page_used[i])
                    begin
                        start = i + 1;
                        run   = 0;
                    end
                    else
                        run++;
                    if (run == cnt)
                        found = 1;
                end
            end
            if (found)
            begin
                for (int i = 0; i < cnt; i++)
                    page_used[start + i] = 1'b1;
                free_pages -= cnt;
                run_addr = lo + (64'(start) << SHIFT);
                exp_rsp.status      = cpba_pkg::ST_OK;
                exp_rsp.run_index   = start[cpba_pkg::INDEX_W-1:0];
                exp_rsp.run_address = run_addr[cpba_pkg::ADDR_W-1:0];
                n_alloc_ok++;
            end
            else
                n_reject++;
        end
        else
        begin
            va   = {16'b0, addr};
            hi   = lo + (64'(PAGES) << SHIFT);
            used = PAGES - free_pages;
            if (va < lo || va >= hi)
            begin
                exp_rsp.status = cpba_pkg::ST_BAD_ADDR;
                n_reject++;
            end
            else if (cnt > used)
            begin
                exp_rsp.status = cpba_pkg::ST_OVER_FREE;
                n_reject++;
            end
            else
            begin
                idx = 32'((va - lo) >> SHIFT);
                // clipped at the last page, but the count still rises by cnt
                for (int i = idx; i < PAGES && (i - idx) < cnt; i++)
                    page_used[i] = 1'b0;
                free_pages += cnt;
                if (free_pages >= PAGES)
                begin
                    free_pages = PAGES;
                    foreach (page_used[i])
                        page_used[i] = 1'b0;
                end
                run_addr = lo + (64'(idx) << SHIFT);
                exp_rsp.status        = cpba_pkg::ST_OK;
                exp_rsp.run_index     = idx[cpba_pkg::INDEX_W-1:0];
                exp_rsp.run_address   = run_addr[cpba_pkg::ADDR_W-1:0];
                exp_rsp.segment_empty = (free_pages == PAGES);
                n_free_ok++;
                if (free_pages == PAGES)
                    n_empty++;
            end
        end
        exp_rsp.pages_available = free_pages[cpba_pkg::AVAIL_W-1:0];
        awaited.push_back(exp_rsp);
    endfunction

    function void check_result(input alloc_result_t got);
        alloc_result_t want;

        if (awaited.size() == 0)
        begin
            mismatches++;
            $display("%0t: unexpected response, expected none, got status %0d index %0d",
                     $time, got.status, got.run_index);
            return;
        end
        want = awaited.pop_front();
        if (got.status !== want.status)
        begin
            mismatches++;
            $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
        end
        if (got.run_address !== want.run_address)
        begin
            mismatches++;
            $display("%0t: run_address expected %h, got %h", $time,
                     want.run_address, got.run_address);
        end
        if (got.run_index !== want.run_index)
        begin
            mismatches++;
            $display("%0t: run_index expected %0d, got %0d", $time,
                     want.run_index, got.run_index);
        end
        if (got.pages_available !== want.pages_available)
        begin
            mismatches++;
            $display("%0t: pages_available expected %0d, got %0d", $time,
                     want.pages_available, got.pages_available);
        end
        if (got.segment_empty !== want.segment_empty)
        begin
            mismatches++;
            $display("%0t: segment_empty expected %0d, got %0d", $time,
                     want.segment_empty, got.segment_empty);
        end
    endfunction
endclass

module tb_contiguous_page_bitmap_allocator;
    import cpba_pkg::*;

    localparam int PAGES       = PAGES_PER_SEGMENT_DEF;
    localparam int SHIFT       = PAGE_SHIFT_DEF;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [ADDR_W-1:0] cfg_wdata;

    cpba_req_if req_ch();
    cpba_rsp_if rsp_ch();

    contiguous_page_bitmap_allocator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    page_alloc_scoreboard sb = new;

    int idle_cycles = 0;
    int n_sent      = 0;
    int n_received  = 0;
    int send_burst  = 0;
    int recv_burst  = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Per-request or per-response wait; now and then a run of back-to-back ones.
    function automatic int draw_gap(inout int burst);
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            burst = $urandom_range(8, 40);
        return $urandom_range(0, 13);
    endfunction

    // Returns at the falling edge after acceptance with valid still high.
    task automatic send_request(input logic op, input logic [COUNT_W-1:0] cnt,
                                input logic [ADDR_W-1:0] addr);
        int gap;

        gap = draw_gap(send_burst);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.opcode       <= op;
        req_ch.num_pages    <= cnt;
        req_ch.page_address <= addr;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note_request(op, cnt, addr);
        n_sent++;
        @(negedge clk);
    endtask

    task automatic write_base(input logic [ADDR_W-1:0] value);
        req_ch.valid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.set_base(value);
    endtask

    // Mostly allocations and frees of runs that are really in use, plus noise.
    task automatic run_random(input int count);
        int                 kind;
        int                 sel;
        int unsigned        idx;
        int unsigned        len;
        int unsigned        used;
        int unsigned        cnt_i;
        int unsigned        k;
        logic               op;
        logic [63:0]        r;
        logic [63:0]        a64;
        logic [ADDR_W-1:0]  addr;

        for (int n = 0; n < count; n++)
        begin
            r     = {$urandom(), $urandom()};
            addr  = r[ADDR_W-1:0];
            kind  = $urandom_range(0, 99);
            used  = PAGES - sb.free_pages;
            op    = OP_ALLOC;
            cnt_i = 0;
            if (kind < 45 || (kind < 85 && used == 0))
            begin
                sel = $urandom_range(0, 19);
                if (sel == 0)
                    cnt_i = 0;
                else if (sel == 1)
                    cnt_i = $urandom_range(513, 1023);
                else if (sel < 4)
                    cnt_i = $urandom_range(33, 512);
                else
                    cnt_i = $urandom_range(1, 32);
            end
            else if (kind < 85)
            begin
                op  = OP_FREE;
                idx = $urandom_range(0, PAGES - 1);
                for (k = 0; k < PAGES && !sb.page_used[idx]; k++)
                    idx = (idx + 1) % PAGES;
                len = 0;
                for (k = idx; k < PAGES && sb.page_used[k]; k++)
                    len++;
                if ($urandom_range(0, 9) == 0)
                begin
                    // release every used page in one go
                    idx   = 0;
                    cnt_i = used;
                end
                else if (len == 0)
                    cnt_i = $urandom_range(1, used);
                else
                    cnt_i = $urandom_range(1, len);
                a64  = {16'b0, sb.base} + (64'(idx) << SHIFT)
                       + 64'($urandom_range(0, (1 << SHIFT) - 1));
                addr = a64[ADDR_W-1:0];
            end
            else
            begin
                op    = OP_FREE;
                sel   = $urandom_range(0, 5);
                a64   = {16'b0, sb.base} + (64'($urandom_range(0, PAGES - 1)) << SHIFT);
                cnt_i = $urandom_range(0, 1023);
                if (sel == 1)
                    a64 = {16'b0, sb.base} - 64'd1;
                else if (sel == 2)
                    a64 = {16'b0, sb.base} + (64'(PAGES) << SHIFT);
                else if (sel == 3)
                    cnt_i = (used < 1023) ? $urandom_range(used + 1, 1023) : 1023;
                else if (sel == 4)
                    cnt_i = 0;
                if (sel != 0)
                    addr = a64[ADDR_W-1:0];
            end
            if (cnt_i > 1023)
                cnt_i = 1023;
            send_request(op, cnt_i[COUNT_W-1:0], addr);
        end
    endtask

    initial
    begin
        alloc_result_t got;
        int            gap;

        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            gap = draw_gap(recv_burst);
            // long hold-off so the block backs up and stalls its request side
            if (n_received == 250 || n_received == 1000)
                gap = HOLD_CYCLES;
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_ch.valid);
            got.status          = status_t'(rsp_ch.status);
            got.run_address     = rsp_ch.run_address;
            got.run_index       = rsp_ch.run_index;
            got.pages_available = rsp_ch.pages_available;
            got.segment_empty   = rsp_ch.segment_empty;
            sb.check_result(got);
            n_received++;
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no request or response moved for %0d cycles", $time, idle_cycles);
            $display("Mismatches found");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        logic [63:0] r;

        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = '0;
        req_ch.valid        = 1'b0;
        req_ch.opcode       = OP_ALLOC;
        req_ch.num_pages    = '0;
        req_ch.page_address = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_base('0);
        send_request(OP_ALLOC, 10'd0, '0);          // zero count
        send_request(OP_ALLOC, 10'd513, '1);        // larger than the segment
        send_request(OP_ALLOC, 10'd1023, '0);
        send_request(OP_FREE, 10'd0, 48'h0);        // zero-count free inside segment
        send_request(OP_FREE, 10'd1, 48'h0);        // nothing used yet
        send_request(OP_ALLOC, 10'd1, '0);
        send_request(OP_ALLOC, 10'd512, '0);        // only 511 left
        send_request(OP_ALLOC, 10'd511, '0);        // fills the segment
        send_request(OP_ALLOC, 10'd1, '0);          // full
        send_request(OP_FREE, 10'd3, 48'h5abc);     // address inside a page
        send_request(OP_ALLOC, 10'd3, '0);          // refills the hole
        send_request(OP_FREE, 10'd4, 48'h1ff000);   // last page, run past the end
        send_request(OP_FREE, 10'd1, 48'h200000);   // one byte past the segment
        send_request(OP_FREE, 10'd1, '1);
        send_request(OP_FREE, 10'd1023, 48'h0);     // exceeds used pages
        send_request(OP_FREE, 10'd508, 48'h0);      // count reaches full, map wiped
        send_request(OP_ALLOC, 10'd512, '0);
        send_request(OP_FREE, 10'd512, 48'h1fffff); // last byte of the segment
        run_random(400);

        write_base('1);
        run_random(60);

        r = {$urandom(), $urandom()};
        write_base(r[ADDR_W-1:0] & ~48'hfff);
        run_random(400);

        // segment ends exactly at the top of the address space
        write_base(48'hffff_ffe0_0000);
        run_random(300);

        r = {$urandom(), $urandom()};
        write_base({8'hff, r[39:0]});
        run_random(340);

        req_ch.valid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);

        $display("%0d requests over 5 segment bases: %0d runs allocated, %0d runs freed,",
                 n_sent, sb.n_alloc_ok, sb.n_free_ok);
        $display("%0d rejected, segment emptied %0d times, %0d responses checked",
                 sb.n_reject, sb.n_empty, n_received);
        if (sb.mismatches == 0 && sb.awaited.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
